// ===== hw/rtl/scd_pkg.sv =====
// Shared types, widths and helpers for the stereo cubic delay with feedback.
package scd_pkg;

  // Sample and datapath widths
  localparam int SW   = 24;  // audio sample, signed Q1.23
  localparam int TW   = 29;  // interpolation accumulator
  localparam int A1W  = 28;  // second polynomial coefficient
  localparam int A2W  = 25;  // third polynomial coefficient
  localparam int MBW  = 17;  // multiplier second operand
  localparam int PRW  = TW + MBW;  // product
  localparam int RW   = 26;  // rounded feedback term
  localparam int DW   = 33;  // delay word, unsigned Q17.16

  localparam logic [15:0] LP_COEFF_RESET = 16'd51909;

  localparam logic signed [31:0] S24_MAX = 32'sd8388607;
  localparam logic signed [31:0] S24_MIN = -32'sd8388608;

  // Input request and result payloads
  typedef struct packed {
    logic signed [SW-1:0] write_mid;
    logic signed [SW-1:0] write_side;
    logic        [DW-1:0] delay_q16;
    logic signed [15:0]   feedback_gain;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] delayed_mid;
    logic signed [SW-1:0] delayed_side;
  } out_t;

  // Lane datapath operations
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_COEF    = 4'd1,
    OP_MUL_F   = 4'd2,
    OP_ACC_A1  = 4'd3,
    OP_ACC_A2  = 4'd4,
    OP_ACC_END = 4'd5,
    OP_OUT     = 4'd6,
    OP_MUL_C   = 4'd7,
    OP_LP      = 4'd8,
    OP_MUL_G   = 4'd9
  } lane_op_t;

  // Control from the sequencer to each lane
  typedef struct packed {
    logic     load;   // capture ring read data into a tap
    logic [1:0] tap;  // which of the four taps
    logic     zero;   // entry never written: take zero
    lane_op_t op;
  } lane_ctrl_t;

  // Saturate to 24 bits signed
  function automatic logic signed [SW-1:0] sat_s24(input logic signed [31:0] x);
    logic signed [SW-1:0] r;
    if (x > S24_MAX) begin
      r = S24_MAX[SW-1:0];
    end else if (x < S24_MIN) begin
      r = S24_MIN[SW-1:0];
    end else begin
      r = x[SW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/stereo_cubic_delay_feedback.sv =====
// Top level: stereo fractional delay line with cubic interpolation and feedback.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) takes one request: a mid and a side
//   sample, a Q17.16 delay and a Q1.15 feedback gain. The result channel
//   (out_valid/out_ready/out_data) returns the two interpolated delayed samples.
//   cfg_we/cfg_wdata write the lowpass coefficient; write it only while idle.
// Sequencing
//   One request at a time: a new request is not accepted until the result is
//   loaded into the output register, and in_ready returns in that same cycle.
//   The sequencer runs four reads through the single read port of each ring RAM,
//   then five multiply steps per lane on one shared multiplier, each followed by
//   its rounding and accumulate step.
// Reset
//   rst_n clears the pointer and the lowpass states and returns the coefficient
//   to its reset value. The ring is not swept: an entry not yet written since
//   reset reads as zero.
// Stall
//   A finished result sits in the output register; if out_ready is low the
//   sequencer holds before loading the next result, and in_ready stays low.
module stereo_cubic_delay_feedback #(
  parameter int DEPTH = 131072
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  scd_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output scd_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 17;
  localparam int CW = (PW > scd_pkg::DW) ? PW : scd_pkg::DW;
  localparam logic [PW-1:0] SPAN    = PW'(DEPTH) << 16;
  localparam logic [PW-1:0] POS_OFS = SPAN - (PW'(1) << 16);
  localparam logic [CW-1:0] D_LO    = CW'(2) << 16;
  localparam logic [CW-1:0] D_HI    = CW'(DEPTH - 3) << 16;
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  typedef enum logic [18:0] {
    S_IDLE  = 19'b1 << 0,
    S_CLAMP = 19'b1 << 1,
    S_POS   = 19'b1 << 2,
    S_ADDR  = 19'b1 << 3,
    S_RD    = 19'b1 << 4,
    S_WAIT  = 19'b1 << 5,
    S_COEF  = 19'b1 << 6,
    S_M1    = 19'b1 << 7,
    S_A1    = 19'b1 << 8,
    S_M2    = 19'b1 << 9,
    S_A2    = 19'b1 << 10,
    S_M3    = 19'b1 << 11,
    S_A3    = 19'b1 << 12,
    S_OUT   = 19'b1 << 13,
    S_MC    = 19'b1 << 14,
    S_LP    = 19'b1 << 15,
    S_MG    = 19'b1 << 16,
    S_FB    = 19'b1 << 17,
    S_DONE  = 19'b1 << 18
  } state_t;

  state_t              state_r, state_nxt;
  scd_pkg::in_t        req_r;
  scd_pkg::out_t       out_data_r;
  logic                out_valid_r;
  logic [15:0]         coeff_r;
  logic [AW-1:0]       wp_r;
  logic                wrapped_r;
  logic [PW-1:0]       dcl_r;
  logic [PW-1:0]       pos_r;
  logic [15:0]         frac_r;
  logic [AW-1:0]       rd_addr_r;
  logic [1:0]          rd_cnt_r;
  logic                ld_valid_r;
  logic [1:0]          ld_tap_r;
  logic                ld_zero_r;

  logic [CW-1:0]       dx;
  logic [CW-1:0]       dcl_c;
  logic [PW-1:0]       pm;
  logic                can_load;
  logic                in_acc;
  logic                ram_we;
  scd_pkg::lane_ctrl_t lane_ctrl;
  scd_pkg::lane_op_t   op_c;
  logic [scd_pkg::SW-1:0] mid_rd, side_rd;
  logic signed [scd_pkg::SW-1:0] mid_dly, side_dly, mid_wr, side_wr;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign ram_we   = (state_r == S_FB);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_POS;
      S_POS:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_RD;
      S_RD:    if (rd_cnt_r == 2'd3) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_COEF;
      S_COEF:  state_nxt = S_M1;
      S_M1:    state_nxt = S_A1;
      S_A1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_A2;
      S_A2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_A3;
      S_A3:    state_nxt = S_OUT;
      S_OUT:   state_nxt = S_MC;
      S_MC:    state_nxt = S_LP;
      S_LP:    state_nxt = S_MG;
      S_MG:    state_nxt = S_FB;
      S_FB:    state_nxt = S_DONE;
      S_DONE:  if (can_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // lane operation per step
  always_comb begin
    unique case (state_r)
      S_COEF:                op_c = scd_pkg::OP_COEF;
      S_M1, S_M2, S_M3:      op_c = scd_pkg::OP_MUL_F;
      S_A1:                  op_c = scd_pkg::OP_ACC_A1;
      S_A2:                  op_c = scd_pkg::OP_ACC_A2;
      S_A3:                  op_c = scd_pkg::OP_ACC_END;
      S_OUT:                 op_c = scd_pkg::OP_OUT;
      S_MC:                  op_c = scd_pkg::OP_MUL_C;
      S_LP:                  op_c = scd_pkg::OP_LP;
      S_MG:                  op_c = scd_pkg::OP_MUL_G;
      default:               op_c = scd_pkg::OP_NONE;
    endcase
    lane_ctrl.load = ld_valid_r;
    lane_ctrl.tap  = ld_tap_r;
    lane_ctrl.zero = ld_zero_r;
    lane_ctrl.op   = op_c;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  // delay clamp, read position and start address (entry behind idx)
  always_comb begin
    dx = CW'(req_r.delay_q16);
    if (dx < D_LO) begin
      dcl_c = D_LO;
    end else if (dx > D_HI) begin
      dcl_c = D_HI;
    end else begin
      dcl_c = dx;
    end
    pm = (pos_r >= SPAN) ? (pos_r - SPAN) : pos_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLAMP) begin
      dcl_r <= dcl_c[PW-1:0];
    end
    if (state_r == S_POS) begin
      pos_r <= PW'({wp_r, 16'h0000}) + POS_OFS - dcl_r;
    end
    if (state_r == S_ADDR) begin
      frac_r <= pm[15:0];
    end
  end

  // read address walk over the four taps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      ld_valid_r <= 1'b0;
      ld_tap_r   <= '0;
      ld_zero_r  <= 1'b0;
    end else begin
      ld_valid_r <= (state_r == S_RD);
      ld_tap_r   <= rd_cnt_r;
      ld_zero_r  <= !(wrapped_r || (rd_addr_r < wp_r));
      if (state_r == S_RD) begin
        rd_cnt_r <= rd_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) begin
      rd_addr_r <= pm[AW+15:16];
    end else if (state_r == S_RD) begin
      rd_addr_r <= (rd_addr_r == LAST) ? '0 : rd_addr_r + AW'(1);
    end
  end

  // write pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (ram_we) begin
      if (wp_r == LAST) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  // coefficient register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= scd_pkg::LP_COEFF_RESET;
    end else if (cfg_we) begin
      coeff_r <= cfg_wdata;
    end
  end

  // ring memories
  scd_ram #(.WIDTH(scd_pkg::SW), .DEPTH(DEPTH)) u_mid_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (mid_wr),
    .raddr (rd_addr_r),
    .rdata (mid_rd)
  );

  scd_ram #(.WIDTH(scd_pkg::SW), .DEPTH(DEPTH)) u_side_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (side_wr),
    .raddr (rd_addr_r),
    .rdata (side_rd)
  );

  // lanes
  scd_lane u_mid_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .rd_data ($signed(mid_rd)),
    .frac    (frac_r),
    .coeff   (coeff_r),
    .gain    (req_r.feedback_gain),
    .sample  (req_r.write_mid),
    .delayed (mid_dly),
    .wr_data (mid_wr)
  );

  scd_lane u_side_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .rd_data ($signed(side_rd)),
    .frac    (frac_r),
    .coeff   (coeff_r),
    .gain    (req_r.feedback_gain),
    .sample  (req_r.write_side),
    .delayed (side_dly),
    .wr_data (side_wr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_DONE) && can_load) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && can_load) begin
      out_data_r.delayed_mid  <= mid_dly;
      out_data_r.delayed_side <= side_dly;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CLAMP))
    else $error("accepted request did not start the sequence");

  a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FB) |=> (wp_r != $past(wp_r)))
    else $error("write pointer did not advance after ring write");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wp_r} < (AW+1)'(DEPTH))
    else $error("write pointer beyond ring depth");

  a_load_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid_r |-> $past(state_r == S_RD))
    else $error("tap load without a preceding ring read");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

endmodule

// ===== hw/rtl/scd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module scd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/scd_lane.sv =====
// One lane: Catmull-Rom interpolation, feedback lowpass and feedback sum.
module scd_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scd_pkg::lane_ctrl_t        ctrl,
  input  logic signed [scd_pkg::SW-1:0] rd_data,
  input  logic        [15:0]         frac,
  input  logic        [15:0]         coeff,
  input  logic signed [15:0]         gain,
  input  logic signed [scd_pkg::SW-1:0] sample,
  output logic signed [scd_pkg::SW-1:0] delayed,
  output logic signed [scd_pkg::SW-1:0] wr_data
);

  localparam int SW  = scd_pkg::SW;
  localparam int TW  = scd_pkg::TW;
  localparam int MBW = scd_pkg::MBW;
  localparam int PRW = scd_pkg::PRW;
  localparam int RW  = scd_pkg::RW;

  logic signed [SW-1:0]          y_r [4];
  logic signed [TW-1:0]          t_r;
  logic signed [scd_pkg::A1W-1:0] a1_r;
  logic signed [scd_pkg::A2W-1:0] a2_r;
  logic signed [PRW-1:0]         prod_r;
  logic signed [SW-1:0]          delayed_r;
  logic signed [SW-1:0]          lp_r;

  logic signed [TW-1:0]  e0, e1, e2, e3;
  logic signed [TW-1:0]  a0_c, a1_c, a2_c;
  logic signed [TW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PRW-1:0] mul_p;
  logic signed [PRW:0]   rs16, rs15;
  logic signed [TW-1:0]  r16_t;
  logic signed [RW-1:0]  r15_t;
  logic signed [TW:0]    tr1;
  logic signed [TW-1:0]  half_t;
  logic signed [TW:0]    ysum;
  logic signed [SW-1:0]  dly_c;
  logic signed [SW:0]    diff_c;
  logic signed [TW:0]    lp_sum;
  logic signed [RW:0]    fb_sum;

  // doubled Catmull-Rom coefficients
  always_comb begin
    e0   = TW'(y_r[0]);
    e1   = TW'(y_r[1]);
    e2   = TW'(y_r[2]);
    e3   = TW'(y_r[3]);
    a0_c = (e1 + (e1 <<< 1)) + e3 - e0 - (e2 + (e2 <<< 1));
    a1_c = (e0 <<< 1) + (e2 <<< 2) - (e1 <<< 2) - e1 - e3;
    a2_c = e2 - e0;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (ctrl.op)
      scd_pkg::OP_MUL_C: begin
        mul_a = t_r;
        mul_b = $signed({1'b0, coeff});
      end
      scd_pkg::OP_MUL_G: begin
        mul_a = TW'(lp_r);
        mul_b = MBW'(gain);
      end
      default: begin
        mul_a = t_r;
        mul_b = $signed({1'b0, frac});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding of the registered product, and the sums that follow it
  always_comb begin
    rs16   = (PRW+1)'(prod_r) + (PRW+1)'(32768);
    rs15   = (PRW+1)'(prod_r) + (PRW+1)'(16384);
    r16_t  = $signed(rs16[TW+15:16]);
    r15_t  = $signed(rs15[RW+14:15]);
    tr1    = (TW+1)'(t_r) + (TW+1)'(1);
    half_t = $signed(tr1[TW:1]);
    ysum   = (TW+1)'(y_r[1]) + (TW+1)'(half_t);
    dly_c  = scd_pkg::sat_s24(32'(ysum));
    diff_c = (SW+1)'(dly_c) - (SW+1)'(lp_r);
    lp_sum = (TW+1)'(lp_r) + (TW+1)'(r16_t);
    fb_sum = (RW+1)'(sample) + (RW+1)'(r15_t);
  end

  // tap capture from the ring read
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      y_r[ctrl.tap] <= ctrl.zero ? '0 : rd_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      scd_pkg::OP_COEF: begin
        t_r  <= a0_c;
        a1_r <= a1_c[scd_pkg::A1W-1:0];
        a2_r <= a2_c[scd_pkg::A2W-1:0];
      end
      scd_pkg::OP_MUL_F, scd_pkg::OP_MUL_C, scd_pkg::OP_MUL_G: begin
        prod_r <= mul_p;
      end
      scd_pkg::OP_ACC_A1: t_r <= r16_t + TW'(a1_r);
      scd_pkg::OP_ACC_A2: t_r <= r16_t + TW'(a2_r);
      scd_pkg::OP_ACC_END: t_r <= r16_t;
      scd_pkg::OP_OUT: begin
        delayed_r <= dly_c;
        t_r       <= TW'(diff_c);
      end
      default: begin
      end
    endcase
  end

  // lowpass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
    end else if (ctrl.op == scd_pkg::OP_LP) begin
      lp_r <= scd_pkg::sat_s24(32'(lp_sum));
    end
  end

  assign delayed = delayed_r;
  assign wr_data = scd_pkg::sat_s24(32'(fb_sum));

endmodule

// ===== tb/sv/stereo_cubic_delay_feedback_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stereo cubic delay line with lowpassed feedback.
module stereo_cubic_delay_feedback_tb;

  localparam int     RING_DEPTH   = 131072;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     PHASE_ITEMS  = 180;
  localparam longint DLY_LO       = 2 * 65536;
  localparam longint DLY_HI       = longint'(RING_DEPTH - 3) * 65536;

  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = 24'sh800000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  scd_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  scd_pkg::out_t out_data;
  logic          cfg_we;
  logic [15:0]   cfg_wdata;

  int requests_sent = 0;
  int coeff_writes  = 0;
  int cycle_count   = 0;
  bit pressure_done = 1'b0;

  // Delay line predictor plus the queue of delayed samples still owed by the block
  class delay_scoreboard;
    int            ring [2][RING_DEPTH];
    int            lp_state [2];
    int unsigned   wr_ptr;
    logic [15:0]   coeff;
    scd_pkg::out_t expected_q[$];
    int            mismatches;
    int            checked;

    function new();
      wr_ptr      = 0;
      coeff       = scd_pkg::LP_COEFF_RESET;
      lp_state[0] = 0;
      lp_state[1] = 0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_coeff(logic [15:0] c);
      coeff = c;
    endfunction

    function int clip24(longint x);
      if (x > 8388607) return 8388607;
      if (x < -8388608) return -8388608;
      return int'(x);
    endfunction

    // round half up, then arithmetic shift (floor)
    function longint round_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Catmull-Rom over the four entries around idx, Horner form with doubled terms
    function int cubic_tap(int ln, int unsigned idx, longint f);
      longint y0, y1, y2, y3, a0, a1, a2, t;
      y0 = ring[ln][(idx + RING_DEPTH - 1) % RING_DEPTH];
      y1 = ring[ln][idx % RING_DEPTH];
      y2 = ring[ln][(idx + 1) % RING_DEPTH];
      y3 = ring[ln][(idx + 2) % RING_DEPTH];
      a0 = -y0 + 3 * y1 - 3 * y2 + y3;
      a1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      a2 = y2 - y0;
      t  = round_shift(a0 * f, 16) + a1;
      t  = round_shift(t * f, 16) + a2;
      t  = round_shift(t * f, 16);
      return clip24(y1 + round_shift(t, 1));
    endfunction

    function void note_request(scd_pkg::in_t req);
      longint        d, span, pos, f, g, din;
      int unsigned   idx;
      int            delayed [2];
      scd_pkg::out_t exp_res;
      d = longint'(req.delay_q16);
      if (d < DLY_LO) d = DLY_LO;
      if (d > DLY_HI) d = DLY_HI;
      span = longint'(RING_DEPTH) * 65536;
      pos  = longint'(wr_ptr) * 65536 + span - d;
      if (pos >= span) pos -= span;
      idx = int'(pos >>> 16);
      f   = pos & 65535;
      g   = longint'($signed(req.feedback_gain));
      for (int ln = 0; ln < 2; ln++) begin
        din = (ln == 0) ? longint'($signed(req.write_mid)) : longint'($signed(req.write_side));
        delayed[ln]  = cubic_tap(ln, idx, f);
        lp_state[ln] = clip24(longint'(lp_state[ln]) +
                              round_shift(longint'(coeff) *
                                          longint'(delayed[ln] - lp_state[ln]), 16));
        ring[ln][wr_ptr] = clip24(din + round_shift(longint'(lp_state[ln]) * g, 15));
      end
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      exp_res.delayed_mid  = delayed[0][23:0];
      exp_res.delayed_side = delayed[1][23:0];
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(scd_pkg::out_t got);
      scd_pkg::out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding: mid %0d side %0d",
                 $time, got.delayed_mid, got.delayed_side);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.delayed_mid !== want.delayed_mid) begin
        mismatches++;
        $display("%0t: delayed_mid mismatch: expected %0d, got %0d",
                 $time, want.delayed_mid, got.delayed_mid);
      end
      if (got.delayed_side !== want.delayed_side) begin
        mismatches++;
        $display("%0t: delayed_side mismatch: expected %0d, got %0d",
                 $time, want.delayed_side, got.delayed_side);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  delay_scoreboard sb;

  stereo_cubic_delay_feedback #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one request, with random gaps outside the calm window
  task automatic send_request(input scd_pkg::in_t req);
    bit calm;
    @(negedge clk);
    calm = (requests_sent >= 650 && requests_sent < 850);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Coefficient change only once the block has drained
  task automatic write_coeff(input logic [15:0] value);
    hold_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_coeff(value);
    coeff_writes++;
  endtask

  function automatic scd_pkg::in_t make_request(logic [23:0] mid, logic [23:0] side,
                                                logic [32:0] dly, logic [15:0] gain);
    scd_pkg::in_t r;
    r.write_mid     = mid;
    r.write_side    = side;
    r.delay_q16     = dly;
    r.feedback_gain = gain;
    return r;
  endfunction

  function automatic logic [23:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? SMP_MAX : SMP_MIN;
    if (pick < 25) return 24'(int'($urandom_range(512)) - 256);
    return 24'($urandom);
  endfunction

  // Mostly short delays over freshly written data, some long and out-of-range ones
  function automatic scd_pkg::in_t random_request();
    scd_pkg::in_t r;
    int           pick;
    r.write_mid  = random_sample();
    r.write_side = random_sample();
    pick = $urandom_range(99);
    if (pick < 55)      r.delay_q16 = {17'($urandom_range(48, 2)), 16'($urandom)};
    else if (pick < 65) r.delay_q16 = {17'($urandom_range(16, 2)), 16'h0000};
    else if (pick < 75) r.delay_q16 = {17'($urandom_range(requests_sent + 4, 2)),
                                        16'($urandom)};
    else if (pick < 83) r.delay_q16 = {17'($urandom_range(RING_DEPTH - 3, 2)),
                                        16'($urandom)};
    else if (pick < 93) r.delay_q16 = {1'($urandom), 32'($urandom)};
    else                r.delay_q16 = 33'($urandom_range(2 * 65536 - 1));
    pick = $urandom_range(99);
    if (pick < 70)      r.feedback_gain = 16'(int'($urandom_range(57670)) - 28835);
    else if (pick < 85) r.feedback_gain = 16'($urandom);
    else if (pick < 92) r.feedback_gain = 16'sh8000;
    else                r.feedback_gain = 16'sh7FFF;
    return r;
  endfunction

  // Result side: random stalls, one long hold while the sender keeps offering
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressure_done && requests_sent >= 400) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= (sb.checked >= 650 && sb.checked < 850) || ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stereo_cubic_delay_feedback verification failed");
    $finish;
  end

  initial begin
    logic [15:0] phase_coeff [6];
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Delay clamping at both ends, extreme samples and gains
    send_request(make_request(SMP_MAX, SMP_MIN, 33'd0, 16'sd0));
    send_request(make_request(SMP_MIN, SMP_MAX, 33'(DLY_LO), 16'sh7FFF));
    send_request(make_request(SMP_MAX, SMP_MIN, 33'(DLY_LO) | 33'hFFFF, 16'sh8000));
    send_request(make_request(24'sd0, 24'sd0, {33{1'b1}}, 16'sh8000));
    send_request(make_request(24'sd1, -24'sd1, 33'(DLY_HI), 16'sh4000));
    send_request(make_request(-24'sd1, 24'sd1, 33'(DLY_HI) + 33'd1, 16'shC000));
    send_request(make_request(SMP_MAX, SMP_MAX, 33'd1, 16'sd0));

    // Write min/max/max/min with no feedback, then read its midpoint: interpolation overshoots
    send_request(make_request(SMP_MIN, SMP_MAX, 33'(DLY_LO), 16'sd0));
    send_request(make_request(SMP_MAX, SMP_MIN, 33'(DLY_LO), 16'sd0));
    send_request(make_request(SMP_MAX, SMP_MIN, 33'(DLY_LO), 16'sd0));
    send_request(make_request(SMP_MIN, SMP_MAX, 33'(DLY_LO), 16'sd0));
    send_request(make_request(24'sd0, 24'sd0, 33'h28000, 16'sd0));

    // Lowpass now near full scale: full gain saturates the write sums
    send_request(make_request(SMP_MAX, SMP_MIN, 33'h28000, 16'sh7FFF));
    send_request(make_request(SMP_MIN, SMP_MAX, 33'h28000, 16'sh8000));

    // Two-sample delay picks up the entry under the pointer; plain integer delay
    send_request(make_request(24'sd12345, -24'sd12345, 33'(DLY_LO), 16'sd16384));
    send_request(make_request(24'sd0, 24'sd0, 33'h30000, 16'sd0));

    // Random phases, one lowpass setting each
    phase_coeff = '{16'd0, 16'hFFFF, 16'd1, 16'd32768, 16'($urandom),
                    scd_pkg::LP_COEFF_RESET};
    foreach (phase_coeff[p]) begin
      write_coeff(phase_coeff[p]);
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    hold_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d delayed sample pairs from %0d requests across %0d lowpass settings,",
             sb.checked, requests_sent, coeff_writes + 1);
    $display("with a %0d-cycle output hold and delays from below two samples to past the ring.",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("stereo_cubic_delay_feedback verification clean");
    end else begin
      $display("stereo_cubic_delay_feedback verification failed");
    end
    $finish;
  end

endmodule
